### rtl/lut3d_tetrahedral_interp_core_assert.svh
// assertion macros of the lut3d rtl
// depends on nothing; the core module includes it by bare file name
`ifndef LUT3D_TETRAHEDRAL_INTERP_CORE_ASSERT_SVH
`define LUT3D_TETRAHEDRAL_INTERP_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define LUT3D_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lut3d assertion failed");

// next-cycle implication, disabled during reset
`define LUT3D_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lut3d assertion failed");

`endif

### rtl/lut3d_pkg.sv
// types and constants of the 3d lut tetrahedral interpolator
// no dependencies; used by every lut3d module except lut3d_ram
`timescale 1ns / 1ps
package lut3d_pkg;

  localparam int MAX_GRID    = 33;
  localparam int TABLE_DEPTH = MAX_GRID * MAX_GRID * MAX_GRID;
  localparam int CH_W        = 17;
  localparam int IDX_W       = 16;
  localparam int ALPHA_W     = 16;
  localparam int GRID_W      = 6;
  localparam int FRAC_SH     = 16;
  localparam int CELL_W      = $clog2(MAX_GRID);
  localparam int SCALED_W    = CH_W + GRID_W;
  localparam int T_W         = $clog2(MAX_GRID * MAX_GRID + 1);
  localparam int CORNERS     = 8;
  localparam int RAM_COPIES  = CORNERS / 2;
  localparam int CFG_AW      = 3;
  localparam int CFG_DW      = 32;

  localparam logic [CH_W-1:0] ONE_FIX = CH_W'(65536);

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_PIXEL = 1'b1;

  localparam logic [CFG_AW-1:0] ADDR_GRID_SIZE = CFG_AW'(0);

  typedef struct packed {
    logic               command;
    logic [IDX_W-1:0]   entry_index;
    logic [CH_W-1:0]    red;
    logic [CH_W-1:0]    green;
    logic [CH_W-1:0]    blue;
    logic [ALPHA_W-1:0] alpha;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0]    out_red;
    logic [CH_W-1:0]    out_green;
    logic [CH_W-1:0]    out_blue;
    logic [ALPHA_W-1:0] out_alpha;
  } out_item_t;

  // channel 0 red, 1 green, 2 blue
  typedef logic [2:0][CH_W-1:0] lut_entry_t;

  typedef struct packed {
    logic               valid;
    logic               pixel;
    logic [IDX_W-1:0]   waddr;
    lut_entry_t         wdata;
    logic [IDX_W-1:0]   idx;
    lut_entry_t         frac;
    logic [ALPHA_W-1:0] alpha;
  } fe_item_t;

endpackage

### rtl/lut3d_ram.sv
// generic single-write, dual-read synchronous ram with registered reads
// no dependencies
`timescale 1ns / 1ps
module lut3d_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

### rtl/lut3d_front.sv
// front end: clamp, scale, cell split and linear base index
// depends on lut3d_pkg
`timescale 1ns / 1ps
module lut3d_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               advance,
  input  logic                               in_accept,
  input  lut3d_pkg::in_item_t                in_data,
  input  logic [lut3d_pkg::GRID_W-1:0]       grid_n,
  output lut3d_pkg::fe_item_t                fe_out
);
  import lut3d_pkg::*;

  logic                 a_valid_r;
  in_item_t             a_item_r;

  logic                 b_valid_r;
  in_item_t             b_item_r;
  logic [SCALED_W-1:0]  b_s_r [3];
  logic [SCALED_W-1:0]  b_s_nxt [3];

  logic                 c_valid_r;
  in_item_t             c_item_r;
  logic [CELL_W-1:0]    c_base_r [3];
  lut_entry_t           c_frac_r;
  logic [CELL_W-1:0]    c_base_nxt [3];
  lut_entry_t           c_frac_nxt;

  logic                 d_valid_r;
  in_item_t             d_item_r;
  logic [T_W-1:0]       d_t_r;
  logic [CELL_W-1:0]    d_b_r;
  lut_entry_t           d_frac_r;
  logic [T_W-1:0]       d_t_nxt;

  fe_item_t             fe_r;
  fe_item_t             fe_nxt;

  lut_entry_t           a_ch;
  logic [CH_W-1:0]      x_cl;
  logic [GRID_W-1:0]    scale;
  logic [GRID_W-1:0]    limit;
  logic [SCALED_W-FRAC_SH-1:0] c_raw;

  always_comb begin
    a_ch  = {a_item_r.blue, a_item_r.green, a_item_r.red};
    scale = grid_n - GRID_W'(1);
    limit = grid_n - GRID_W'(2);
    x_cl  = '0;
    c_raw = '0;
    for (int i = 0; i < 3; i++) begin
      x_cl       = (a_ch[i] > ONE_FIX) ? ONE_FIX : a_ch[i];
      b_s_nxt[i] = SCALED_W'(x_cl) * SCALED_W'(scale);
    end
    for (int i = 0; i < 3; i++) begin
      c_raw = b_s_r[i][SCALED_W-1:FRAC_SH];
      if (c_raw > (SCALED_W-FRAC_SH)'(limit)) begin
        c_base_nxt[i] = CELL_W'(limit);
      end else begin
        c_base_nxt[i] = CELL_W'(c_raw);
      end
      c_frac_nxt[i] = CH_W'(b_s_r[i] - {(SCALED_W-FRAC_SH)'(c_base_nxt[i]), FRAC_SH'(0)});
    end
    d_t_nxt = T_W'(c_base_r[0]) * T_W'(grid_n) + T_W'(c_base_r[1]);

    fe_nxt.valid = d_valid_r;
    fe_nxt.pixel = (d_item_r.command == CMD_PIXEL);
    fe_nxt.waddr = d_item_r.entry_index;
    fe_nxt.wdata = {d_item_r.blue, d_item_r.green, d_item_r.red};
    fe_nxt.idx   = IDX_W'(d_t_r) * IDX_W'(grid_n) + IDX_W'(d_b_r);
    fe_nxt.frac  = d_frac_r;
    fe_nxt.alpha = d_item_r.alpha;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
      d_valid_r <= 1'b0;
      fe_r.valid <= 1'b0;
    end else if (advance) begin
      a_valid_r  <= in_accept;
      b_valid_r  <= a_valid_r;
      c_valid_r  <= b_valid_r;
      d_valid_r  <= c_valid_r;
      fe_r.valid <= fe_nxt.valid;
      a_item_r   <= in_data;
      b_item_r   <= a_item_r;
      b_s_r      <= b_s_nxt;
      c_item_r   <= b_item_r;
      c_base_r   <= c_base_nxt;
      c_frac_r   <= c_frac_nxt;
      d_item_r   <= c_item_r;
      d_t_r      <= d_t_nxt;
      d_b_r      <= c_base_r[2];
      d_frac_r   <= c_frac_r;
      fe_r.pixel <= fe_nxt.pixel;
      fe_r.waddr <= fe_nxt.waddr;
      fe_r.wdata <= fe_nxt.wdata;
      fe_r.idx   <= fe_nxt.idx;
      fe_r.frac  <= fe_nxt.frac;
      fe_r.alpha <= fe_nxt.alpha;
    end
  end

  assign fe_out = fe_r;

endmodule

### rtl/lut3d_blend.sv
// back end: tetrahedron pick, weighted edge deltas, rounding and clamp
// depends on lut3d_pkg; corner data comes from the lut rams
`timescale 1ns / 1ps
module lut3d_blend (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   advance,
  input  lut3d_pkg::fe_item_t                    fe_in,
  input  lut3d_pkg::lut_entry_t [lut3d_pkg::CORNERS-1:0] corners,
  output logic                                   out_valid,
  output lut3d_pkg::out_item_t                   out_data
);
  import lut3d_pkg::*;

  localparam int DELTA_W = CH_W + 1;
  localparam int PROD_W  = 2 * DELTA_W;
  localparam int ACC_W   = PROD_W + 2;
  localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(32768);

  localparam logic [2:0] C001 = 3'd1;
  localparam logic [2:0] C010 = 3'd2;
  localparam logic [2:0] C011 = 3'd3;
  localparam logic [2:0] C100 = 3'd4;
  localparam logic [2:0] C101 = 3'd5;
  localparam logic [2:0] C110 = 3'd6;

  logic               f_valid_r;
  logic               f_pixel_r;
  lut_entry_t         f_frac_r;
  logic [ALPHA_W-1:0] f_alpha_r;

  logic               g_valid_r;
  logic               g_pixel_r;
  logic [ALPHA_W-1:0] g_alpha_r;
  lut_entry_t         g_base_r;
  logic signed [PROD_W-1:0] g_prod_r [3][3];
  logic signed [PROD_W-1:0] g_prod_nxt [3][3];

  logic               out_valid_r;
  out_item_t          out_data_r;
  out_item_t          out_data_nxt;

  logic [2:0]         v1;
  logic [2:0]         v2;
  logic [CH_W-1:0]    w [3];
  logic [CH_W-1:0]    fr, fg, fb;
  logic signed [DELTA_W-1:0] dl [3];
  logic signed [ACC_W-1:0]   acc;
  logic [ACC_W-FRAC_SH-1:0]  q;
  logic [CH_W-1:0]    res [3];

  always_comb begin
    fr = f_frac_r[0];
    fg = f_frac_r[1];
    fb = f_frac_r[2];
    if (fr >= fg && fg >= fb) begin
      v1 = C100; v2 = C110; w[0] = fr; w[1] = fg; w[2] = fb;
    end else if (fr >= fb && fb >= fg) begin
      v1 = C100; v2 = C101; w[0] = fr; w[1] = fb; w[2] = fg;
    end else if (fb >= fr && fr >= fg) begin
      v1 = C001; v2 = C101; w[0] = fb; w[1] = fr; w[2] = fg;
    end else if (fg >= fr && fr >= fb) begin
      v1 = C010; v2 = C110; w[0] = fg; w[1] = fr; w[2] = fb;
    end else if (fg >= fb && fb >= fr) begin
      v1 = C010; v2 = C011; w[0] = fg; w[1] = fb; w[2] = fr;
    end else begin
      v1 = C001; v2 = C011; w[0] = fb; w[1] = fg; w[2] = fr;
    end
    for (int ch = 0; ch < 3; ch++) begin
      dl[0] = $signed({1'b0, corners[v1][ch]}) - $signed({1'b0, corners[0][ch]});
      dl[1] = $signed({1'b0, corners[v2][ch]}) - $signed({1'b0, corners[v1][ch]});
      dl[2] = $signed({1'b0, corners[CORNERS-1][ch]}) - $signed({1'b0, corners[v2][ch]});
      for (int e = 0; e < 3; e++) begin
        g_prod_nxt[ch][e] = PROD_W'(dl[e]) * PROD_W'($signed({1'b0, w[e]}));
      end
    end
  end

  always_comb begin
    acc = '0;
    q   = '0;
    for (int ch = 0; ch < 3; ch++) begin
      acc = ACC_W'({g_base_r[ch], FRAC_SH'(0)}) + ACC_W'(g_prod_r[ch][0])
          + ACC_W'(g_prod_r[ch][1]) + ACC_W'(g_prod_r[ch][2]) + ROUND_HALF;
      q = acc[ACC_W-1:FRAC_SH];
      if (acc[ACC_W-1]) begin
        res[ch] = '0;
      end else if (q > (ACC_W-FRAC_SH)'(ONE_FIX)) begin
        res[ch] = ONE_FIX;
      end else begin
        res[ch] = CH_W'(q);
      end
    end
    out_data_nxt.out_red   = res[0];
    out_data_nxt.out_green = res[1];
    out_data_nxt.out_blue  = res[2];
    out_data_nxt.out_alpha = g_alpha_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r   <= 1'b0;
      g_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      f_valid_r   <= fe_in.valid;
      g_valid_r   <= f_valid_r;
      out_valid_r <= g_valid_r && g_pixel_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      f_pixel_r  <= fe_in.pixel;
      f_frac_r   <= fe_in.frac;
      f_alpha_r  <= fe_in.alpha;
      g_pixel_r  <= f_pixel_r;
      g_alpha_r  <= f_alpha_r;
      g_base_r   <= corners[0];
      g_prod_r   <= g_prod_nxt;
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/lut3d_tetrahedral_interp_core.sv
// 3d lut colour grading core with tetrahedral interpolation
// depends on lut3d_pkg, lut3d_ram, lut3d_front, lut3d_blend and the assert header
//
// usage: in_data carries either a table write (command write: entry_index
// plus red/green/blue of the entry) or a pixel (command pixel: red, green,
// blue, alpha). each pixel yields one out_data transaction, a write none.
// grid_size is set through the cfg_ apb port at byte address 0; the user must
// write it only while idle, as the block does not enforce this. one transaction
// is taken per clock while in_stall is low. the eight cell corners come from four
// copies of the table, each with two read ports, so every corner read happens in
// the same cycle. the pipeline advances as a whole: when out_stall holds a waiting
// result, in_stall rises and every stage keeps its contents. reset clears valids and
// sets grid_size to 33; table contents are undefined until written.
`timescale 1ns / 1ps
`include "lut3d_tetrahedral_interp_core_assert.svh"
module lut3d_tetrahedral_interp_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  lut3d_pkg::in_item_t              in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output lut3d_pkg::out_item_t             out_data,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [lut3d_pkg::CFG_AW-1:0]     cfg_paddr,
  input  logic [lut3d_pkg::CFG_DW-1:0]     cfg_pwdata,
  output logic [lut3d_pkg::CFG_DW-1:0]     cfg_prdata,
  output logic                             cfg_pready
);
  import lut3d_pkg::*;

  logic [GRID_W-1:0] grid_r;
  logic [GRID_W-1:0] grid_n;
  logic [T_W-1:0]    nsq_r;
  logic              cfg_wr_grid;
  logic              advance;
  logic              in_accept;
  logic              ram_we;
  fe_item_t          fe;
  logic [IDX_W-1:0]  addr [CORNERS];
  wire lut_entry_t [CORNERS-1:0] corners;

  assign cfg_pready  = 1'b1;
  assign cfg_wr_grid = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                       && (cfg_paddr == ADDR_GRID_SIZE);
  assign cfg_prdata  = (cfg_paddr == ADDR_GRID_SIZE) ? CFG_DW'(grid_r) : '0;

  always_comb begin
    if (grid_r < GRID_W'(2)) begin
      grid_n = GRID_W'(2);
    end else if (grid_r > GRID_W'(MAX_GRID)) begin
      grid_n = GRID_W'(MAX_GRID);
    end else begin
      grid_n = grid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_r <= GRID_W'(MAX_GRID);
    end else if (cfg_wr_grid) begin
      grid_r <= cfg_pwdata[GRID_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    nsq_r <= T_W'(grid_n) * T_W'(grid_n);
  end

  assign advance   = !out_valid || !out_stall;
  assign in_stall  = !advance;
  assign in_accept = in_valid && !in_stall;

  lut3d_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .in_accept (in_accept),
    .in_data   (in_data),
    .grid_n    (grid_n),
    .fe_out    (fe)
  );

  // corner k: bit 2 steps red (grid^2), bit 1 green (grid), bit 0 blue
  always_comb begin
    for (int k = 0; k < CORNERS; k++) begin
      addr[k] = fe.idx + (k[2] ? IDX_W'(nsq_r) : '0) + (k[1] ? IDX_W'(grid_n) : '0)
              + IDX_W'(k[0]);
    end
  end

  assign ram_we = advance && fe.valid && !fe.pixel && (fe.waddr < IDX_W'(TABLE_DEPTH));

  for (genvar j = 0; j < RAM_COPIES; j++) begin : g_ram
    lut3d_ram #(
      .DEPTH (TABLE_DEPTH),
      .WIDTH (3 * CH_W),
      .AW    (IDX_W)
    ) u_ram (
      .clk     (clk),
      .we      (ram_we),
      .waddr   (fe.waddr),
      .wdata   (fe.wdata),
      .re      (advance),
      .raddr_a (addr[2*j]),
      .raddr_b (addr[2*j+1]),
      .rdata_a (corners[2*j]),
      .rdata_b (corners[2*j+1])
    );
  end

  lut3d_blend u_blend (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .fe_in     (fe),
    .corners   (corners),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  `LUT3D_ASSERT_IMP(a_hold_backpressure, clk, rst_n, out_valid && out_stall, in_stall)
  `LUT3D_ASSERT_IMP(a_no_write_in_hold, clk, rst_n, ram_we, !(out_valid && out_stall))
  `LUT3D_ASSERT_IMP(a_result_clamped, clk, rst_n, out_valid, out_data.out_red <= ONE_FIX && out_data.out_green <= ONE_FIX && out_data.out_blue <= ONE_FIX)
  `LUT3D_ASSERT_NXT(a_grid_written, clk, rst_n, cfg_wr_grid, grid_r == $past(cfg_pwdata[GRID_W-1:0]))

endmodule

### tb/sv/tb_lut3d_tetrahedral_interp_core.sv
// self-checking testbench for lut3d_tetrahedral_interp_core: table writes and pixels
// depends on lut3d_pkg and the core rtl; predicts every graded pixel in its own model
`timescale 1ns / 1ps
module tb_lut3d_tetrahedral_interp_core;
  import lut3d_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int HOLD_CYCLES    = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [CFG_DW-1:0] cfg_pwdata = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic cfg_pready;

  lut3d_tetrahedral_interp_core DUT (.*);

  always #5 clk = ~clk;

  // predictor state
  lut_entry_t lut_mem [0:TABLE_DEPTH-1];
  bit lut_written [0:TABLE_DEPTH-1];
  logic [GRID_W-1:0] lut_grid = GRID_W'(33);
  out_item_t graded_q[$];

  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int mismatches = 0;
  int writes_sent = 0;
  int pixels_sent = 0;
  int grids_used = 0;
  int idle_cyc = 0;
  int hold_left = 0;
  bit hold_req = 1'b0;

  function automatic int unsigned grid_pts();
    if (lut_grid < 2) return 2;
    if (lut_grid > MAX_GRID) return MAX_GRID;
    return lut_grid;
  endfunction

  function automatic void cell_of(input in_item_t it, output int unsigned base[3],
                                  output int unsigned fr[3]);
    int unsigned n, v, s, c;
    n = grid_pts();
    for (int i = 0; i < 3; i++) begin
      v = (i == 0) ? it.red : (i == 1) ? it.green : it.blue;
      if (v > 65536) v = 65536;
      s = v * (n - 1);
      c = s >> 16;
      if (c > n - 2) c = n - 2;
      base[i] = c;
      fr[i] = s - (c << 16);
    end
  endfunction

  function automatic int unsigned lut_idx(int unsigned r, int unsigned g, int unsigned b);
    int unsigned n;
    n = grid_pts();
    return (r * n + g) * n + b;
  endfunction

  function automatic longint corner_val(int unsigned r, int unsigned g, int unsigned b,
                                        int ch);
    return longint'(lut_mem[lut_idx(r, g, b)][ch]);
  endfunction

  function automatic out_item_t grade_pixel(in_item_t it);
    int unsigned bs[3], fr[3];
    longint c000, c100, c010, c001, c110, c101, c011, c111, acc, f_r, f_g, f_b, t, q;
    logic [CH_W-1:0] res[3];
    out_item_t o;
    cell_of(it, bs, fr);
    f_r = fr[0];
    f_g = fr[1];
    f_b = fr[2];
    for (int ch = 0; ch < 3; ch++) begin
      c000 = corner_val(bs[0], bs[1], bs[2], ch);
      c100 = corner_val(bs[0] + 1, bs[1], bs[2], ch);
      c010 = corner_val(bs[0], bs[1] + 1, bs[2], ch);
      c001 = corner_val(bs[0], bs[1], bs[2] + 1, ch);
      c110 = corner_val(bs[0] + 1, bs[1] + 1, bs[2], ch);
      c101 = corner_val(bs[0] + 1, bs[1], bs[2] + 1, ch);
      c011 = corner_val(bs[0], bs[1] + 1, bs[2] + 1, ch);
      c111 = corner_val(bs[0] + 1, bs[1] + 1, bs[2] + 1, ch);
      acc = c000 * 65536;
      if (f_r >= f_g && f_g >= f_b)
        acc += (c100 - c000) * f_r + (c110 - c100) * f_g + (c111 - c110) * f_b;
      else if (f_r >= f_b && f_b >= f_g)
        acc += (c100 - c000) * f_r + (c101 - c100) * f_b + (c111 - c101) * f_g;
      else if (f_b >= f_r && f_r >= f_g)
        acc += (c001 - c000) * f_b + (c101 - c001) * f_r + (c111 - c101) * f_g;
      else if (f_g >= f_r && f_r >= f_b)
        acc += (c010 - c000) * f_g + (c110 - c010) * f_r + (c111 - c110) * f_b;
      else if (f_g >= f_b && f_b >= f_r)
        acc += (c010 - c000) * f_g + (c011 - c010) * f_b + (c111 - c011) * f_r;
      else
        acc += (c001 - c000) * f_b + (c011 - c001) * f_g + (c111 - c011) * f_r;
      t = acc + 32768;
      if (t < 0) q = 0;
      else q = t >>> 16;
      if (q > 65536) q = 65536;
      res[ch] = CH_W'(q);
    end
    o.out_red = res[0];
    o.out_green = res[1];
    o.out_blue = res[2];
    o.out_alpha = it.alpha;
    return o;
  endfunction

  function automatic void apply_item(in_item_t it);
    if (it.command == CMD_WRITE) begin
      if (it.entry_index < TABLE_DEPTH) begin
        lut_mem[it.entry_index][0] = it.red;
        lut_mem[it.entry_index][1] = it.green;
        lut_mem[it.entry_index][2] = it.blue;
        lut_written[it.entry_index] = 1'b1;
      end
    end else begin
      graded_q.push_back(grade_pixel(it));
    end
  endfunction

  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    apply_item(it);
  endtask

  function automatic logic [CH_W-1:0] rand_entry_val();
    if ($urandom_range(9) == 0) return CH_W'($urandom_range(65537, 131071));
    return CH_W'($urandom_range(0, 65536));
  endfunction

  function automatic logic [CH_W-1:0] rand_pixel_val();
    case ($urandom_range(9))
      0: return '0;
      1: return ONE_FIX;
      2: return CH_W'($urandom_range(65537, 131071));
      default: return CH_W'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic send_write(int unsigned idx, logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                            logic [CH_W-1:0] b);
    in_item_t it;
    it = '0;
    it.command = CMD_WRITE;
    it.entry_index = IDX_W'(idx);
    it.red = r;
    it.green = g;
    it.blue = b;
    it.alpha = ALPHA_W'($urandom);
    send_item(it);
    writes_sent++;
  endtask

  // load any cell corner not yet written so no undefined entry is read
  task automatic send_pixel(logic [CH_W-1:0] r, logic [CH_W-1:0] g, logic [CH_W-1:0] b,
                            logic [ALPHA_W-1:0] a);
    in_item_t it;
    int unsigned bs[3], fr[3], idx;
    it = '0;
    it.command = CMD_PIXEL;
    it.entry_index = IDX_W'($urandom);
    it.red = r;
    it.green = g;
    it.blue = b;
    it.alpha = a;
    cell_of(it, bs, fr);
    for (int k = 0; k < 8; k++) begin
      idx = lut_idx(bs[0] + k[2], bs[1] + k[1], bs[2] + k[0]);
      if (!lut_written[idx])
        send_write(idx, rand_entry_val(), rand_entry_val(), rand_entry_val());
    end
    send_item(it);
    pixels_sent++;
  endtask

  task automatic write_grid(logic [GRID_W-1:0] value);
    in_valid <= 1'b0;
    while (graded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= ADDR_GRID_SIZE;
    cfg_pwdata <= CFG_DW'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    lut_grid = value;
    grids_used++;
  endtask

  task automatic send_random(int count);
    int unsigned n;
    n = grid_pts();
    repeat (count) begin
      case ($urandom_range(9))
        0: send_write($urandom_range(0, n * n * n - 1), rand_entry_val(), rand_entry_val(),
                      rand_entry_val());
        1: send_write($urandom_range(0, 65535), rand_entry_val(), rand_entry_val(),
                      rand_entry_val());
        default: send_pixel(rand_pixel_val(), rand_pixel_val(), rand_pixel_val(),
                            ALPHA_W'($urandom));
      endcase
    end
  endtask

  task automatic test_directed();
    send_write(0, CH_W'(131071), CH_W'(131071), '0);
    send_write(TABLE_DEPTH, '1, '1, '1);
    send_write(65535, '1, '1, '1);
    send_pixel('0, '0, '0, '0);
    send_pixel(ONE_FIX, ONE_FIX, ONE_FIX, '1);
    send_pixel(CH_W'(131071), '0, CH_W'(70000), 16'h5a5a);
    send_pixel(CH_W'(1000), CH_W'(1000), CH_W'(1000), 16'h0001);
    send_pixel(CH_W'(1500), CH_W'(1000), CH_W'(500), 16'h0002);
    send_pixel(CH_W'(1500), CH_W'(500), CH_W'(1000), 16'h0003);
    send_pixel(CH_W'(1000), CH_W'(500), CH_W'(1500), 16'h0004);
    send_pixel(CH_W'(1000), CH_W'(1500), CH_W'(500), 16'h0005);
    send_pixel(CH_W'(500), CH_W'(1500), CH_W'(1000), 16'h0006);
    send_pixel(CH_W'(500), CH_W'(1000), CH_W'(1500), 16'h0007);
    send_pixel(CH_W'(1500), CH_W'(1500), CH_W'(500), 16'h8000);
    send_pixel(ONE_FIX, CH_W'(40000), '0, 16'hfffe);
  endtask

  task automatic test_grid(logic [GRID_W-1:0] value, int count);
    write_grid(value);
    send_random(count);
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    send_random(80);
  endtask

  // result checking and receiver stall
  always @(posedge clk) begin
    out_item_t exp_item;
    logic nxt_stall;
    if (rst_n && out_valid && !out_stall) begin
      if (graded_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data);
      end else begin
        exp_item = graded_q.pop_front();
        if (out_data !== exp_item) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p got %p", exp_item, out_data);
        end
      end
    end
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      nxt_stall = 1'b1;
    end else begin
      nxt_stall = ($urandom_range(99) < rcv_idle_pct);
    end
    out_stall <= nxt_stall;
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) idle_cyc = 0;
    else idle_cyc++;
    if (idle_cyc >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    snd_idle_pct = 21;
    rcv_idle_pct = 55;
    test_directed();
    test_grid(GRID_W'(2), 150);
    test_grid(GRID_W'(0), 120);
    test_grid(GRID_W'(3), 150);
    snd_idle_pct = 55;
    rcv_idle_pct = 21;
    test_grid(GRID_W'(5), 150);
    test_grid(GRID_W'(63), 20);
    test_grid(GRID_W'(9), 30);
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    test_grid(GRID_W'(17), 20);
    test_grid(GRID_W'(33), 25);
    test_grid(GRID_W'(1), 100);
    test_backpressure();
    in_valid <= 1'b0;
    while (graded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("graded %0d pixels after %0d table writes across %0d grid settings",
             pixels_sent, writes_sent, grids_used);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/lut3d_pkg.sv
rtl/lut3d_ram.sv
rtl/lut3d_front.sv
rtl/lut3d_blend.sv
rtl/lut3d_tetrahedral_interp_core.sv
tb/sv/tb_lut3d_tetrahedral_interp_core.sv
